FILE: rtl/lmbc_pkg.sv
package lmbc_pkg;

  // LED counts: mono LEDs first, then the exclusive color group
  localparam int NUM_MONO_LEDS  = 6;
  localparam int NUM_COLOR_LEDS = 3;
  localparam int LED_TOTAL      = NUM_MONO_LEDS + NUM_COLOR_LEDS;
  localparam int IDX_W          = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;
  localparam int BLUE_LED       = LED_TOTAL - 1;
  localparam int MASK_W         = 9;

  // Time indicator LED positions
  localparam int IND_10 = 2;
  localparam int IND_30 = 3;
  localparam int IND_60 = 4;

  localparam logic [31:0] DEFAULT_PERIOD = 32'd500;
  localparam logic [15:0] ALL_INDICATORS = 16'hFF;
  localparam logic [15:0] MINUTES_60     = 16'd60;
  localparam logic [15:0] MINUTES_30     = 16'd30;
  localparam logic [15:0] MINUTES_10     = 16'd10;

  typedef enum logic [1:0] {
    OP_SET_MODE = 2'd0,
    OP_TICK     = 2'd1,
    OP_TIME_SEL = 2'd2,
    OP_READ     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_BLINK = 2'd2
  } mode_e;

  typedef struct packed {
    op_e         operation;
    logic [3:0]  led_sel;
    logic [1:0]  mode_code;
    logic [31:0] blink_interval;
    logic [15:0] minutes;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [MASK_W-1:0] lit_mask;
    logic              read_value;
  } result_t;

  // One LED entry of the state memory
  typedef struct packed {
    mode_e       mode;
    logic [31:0] period;
    logic [31:0] deadline;
  } entry_t;

  // Memory access request from the sequencer
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

  // Reset contents of an entry: blue LED on, everything else off
  function automatic entry_t reset_entry(logic [IDX_W-1:0] idx);
    entry_t e;
    e.mode     = (int'(idx) == BLUE_LED) ? MODE_ON : MODE_OFF;
    e.period   = DEFAULT_PERIOD;
    e.deadline = 32'd0;
    return e;
  endfunction

  // Set one LED; a color LED first darkens its whole group
  function automatic logic [LED_TOTAL-1:0] drive(logic [LED_TOTAL-1:0] lit,
                                                 logic [IDX_W-1:0] idx,
                                                 logic on);
    logic [LED_TOTAL-1:0] res;
    res = lit;
    if (int'(idx) < NUM_MONO_LEDS) begin
      res[idx] = on;
    end else if (int'(idx) < LED_TOTAL) begin
      for (int k = NUM_MONO_LEDS; k < LED_TOTAL; k++) begin
        res[k] = 1'b0;
      end
      res[idx] = on;
    end
    return res;
  endfunction

  // Fit the lit bits to the output mask width
  function automatic logic [MASK_W-1:0] to_mask(logic [LED_TOTAL-1:0] lit);
    logic [LED_TOTAL+MASK_W-1:0] wide;
    wide = {{MASK_W{1'b0}}, lit};
    return wide[MASK_W-1:0];
  endfunction

endpackage

FILE: rtl/lmbc_entry_mem.sv
module lmbc_entry_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lmbc_pkg::mem_req_t req_i,
  output lmbc_pkg::entry_t   rdata_o
);
  import lmbc_pkg::*;

  entry_t               mem_q [LED_TOTAL];
  logic [LED_TOTAL-1:0] vld_q;
  entry_t               rdata_q;
  logic [IDX_W-1:0]     raddr_q;
  logic                 rvld_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
      raddr_q <= req_i.rd_addr;
    end
  end

  // Track written entries; unwritten ones read as reset contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : reset_entry(raddr_q);

endmodule

FILE: rtl/lmbc_seq.sv
module lmbc_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  lmbc_pkg::item_t    item_i,
  output logic               busy_o,
  output logic               done_o,
  output lmbc_pkg::result_t  result_o,
  output lmbc_pkg::mem_req_t mem_req_o,
  input  lmbc_pkg::entry_t   mem_rdata_i
);
  import lmbc_pkg::*;

  localparam int TS_LO = IND_10;
  localparam int TS_HI = (NUM_MONO_LEDS > IND_60) ? IND_60 : NUM_MONO_LEDS - 1;
  localparam bit TS_EN = (NUM_MONO_LEDS > IND_10);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e               state_q;
  item_t                item_q;
  logic [IDX_W-1:0]     rd_ptr_q;
  logic [IDX_W-1:0]     hi_q;
  logic                 rd_act_q;
  logic                 wr_act_q;
  logic [IDX_W-1:0]     wr_idx_q;
  logic [LED_TOTAL-1:0] lit_q;
  logic                 done_q;
  result_t              result_q;

  logic                 accept;
  logic                 rng_act;
  logic [IDX_W-1:0]     rng_lo;
  logic [IDX_W-1:0]     rng_hi;
  entry_t               upd;
  logic [LED_TOTAL-1:0] lit_d;
  logic [31:0]          period_sel;
  logic [31:0]          add_b;
  logic [31:0]          sum;
  logic [31:0]          diff;
  logic                 ind_a;
  logic                 ind_b;
  logic                 ind_c;
  logic                 ind_on;
  logic [LED_TOTAL+15:0] lit_wide;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // Pick the range of entries an item walks
  always_comb begin
    rng_act = 1'b0;
    rng_lo  = '0;
    rng_hi  = '0;
    unique case (item_i.operation)
      OP_SET_MODE: begin
        rng_act = (int'(item_i.led_sel) < LED_TOTAL);
        rng_lo  = IDX_W'(item_i.led_sel);
        rng_hi  = IDX_W'(item_i.led_sel);
      end
      OP_TICK: begin
        rng_act = 1'b1;
        rng_lo  = '0;
        rng_hi  = IDX_W'(BLUE_LED);
      end
      OP_TIME_SEL: begin
        rng_act = TS_EN;
        rng_lo  = IDX_W'(TS_LO);
        rng_hi  = IDX_W'(TS_HI);
      end
      OP_READ: begin
        rng_act = 1'b0;
      end
      default: begin
        rng_act = 1'b0;
      end
    endcase
  end

  // Decode the time indicator selection
  always_comb begin
    ind_a = 1'b0;
    ind_b = 1'b0;
    ind_c = 1'b0;
    priority if (item_q.minutes == ALL_INDICATORS) begin
      ind_a = 1'b1;
      ind_b = 1'b1;
      ind_c = 1'b1;
    end else if (item_q.minutes >= MINUTES_60) begin
      ind_c = 1'b1;
    end else if (item_q.minutes >= MINUTES_30) begin
      ind_b = 1'b1;
    end else if (item_q.minutes >= MINUTES_10) begin
      ind_a = 1'b1;
    end else begin
      // below ten minutes: every indicator stays dark
      ind_a = 1'b0;
    end
    if (int'(wr_idx_q) == IND_10) begin
      ind_on = ind_a;
    end else if (int'(wr_idx_q) == IND_30) begin
      ind_on = ind_b;
    end else begin
      ind_on = ind_c;
    end
  end

  // Modify the entry read last cycle and the lit bits
  assign period_sel = (item_q.blink_interval == 32'd0) ? DEFAULT_PERIOD
                                                       : item_q.blink_interval;
  assign add_b = (item_q.operation == OP_TICK) ? mem_rdata_i.period : period_sel;
  assign sum   = item_q.now_ms + add_b;
  assign diff  = item_q.now_ms - mem_rdata_i.deadline;

  always_comb begin
    upd   = mem_rdata_i;
    lit_d = lit_q;
    unique case (item_q.operation)
      OP_SET_MODE: begin
        if (item_q.mode_code == MODE_BLINK) begin
          upd.mode     = MODE_BLINK;
          upd.period   = period_sel;
          upd.deadline = sum;
          lit_d        = drive(lit_q, wr_idx_q, 1'b1);
        end else if (item_q.mode_code == MODE_ON) begin
          upd.mode = MODE_ON;
          lit_d    = drive(lit_q, wr_idx_q, 1'b1);
        end else begin
          upd.mode = MODE_OFF;
          lit_d    = drive(lit_q, wr_idx_q, 1'b0);
        end
      end
      OP_TICK: begin
        if ((mem_rdata_i.mode == MODE_BLINK) && !diff[31]) begin
          upd.deadline = sum;
          lit_d        = drive(lit_q, wr_idx_q, !lit_q[wr_idx_q]);
        end
      end
      OP_TIME_SEL: begin
        upd.mode = ind_on ? MODE_ON : MODE_OFF;
        lit_d    = drive(lit_q, wr_idx_q, ind_on);
      end
      OP_READ: begin
        upd = mem_rdata_i;
      end
      default: begin
        upd = mem_rdata_i;
      end
    endcase
  end

  // Memory requests: read ahead, write back behind
  always_comb begin
    mem_req_o.rd_en   = (state_q == ST_RUN) && rd_act_q;
    mem_req_o.rd_addr = rd_ptr_q;
    mem_req_o.wr_en   = (state_q == ST_RUN) && wr_act_q;
    mem_req_o.wr_addr = wr_idx_q;
    mem_req_o.wr_data = upd;
  end

  assign lit_wide = {16'd0, lit_q};

  // Hold state, walk entries, emit the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      item_q   <= '0;
      rd_ptr_q <= '0;
      hi_q     <= '0;
      rd_act_q <= 1'b0;
      wr_act_q <= 1'b0;
      wr_idx_q <= '0;
      lit_q    <= drive('0, IDX_W'(BLUE_LED), 1'b1);
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            item_q   <= item_i;
            rd_ptr_q <= rng_lo;
            hi_q     <= rng_hi;
            rd_act_q <= rng_act;
            wr_act_q <= 1'b0;
            state_q  <= ST_RUN;
          end
        end
        ST_RUN: begin
          wr_act_q <= rd_act_q;
          wr_idx_q <= rd_ptr_q;
          if (rd_act_q) begin
            if (rd_ptr_q == hi_q) begin
              rd_act_q <= 1'b0;
            end else begin
              rd_ptr_q <= rd_ptr_q + 1'b1;
            end
          end
          if (wr_act_q) begin
            lit_q <= lit_d;
          end
          if (!rd_act_q && !wr_act_q) begin
            done_q              <= 1'b1;
            result_q.lit_mask   <= to_mask(lit_q);
            result_q.read_value <= (item_q.operation == OP_READ) &&
                                   lit_wide[item_q.led_sel];
            state_q             <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

FILE: rtl/led_mode_blink_controller_core.sv
// An item is taken only while the block is idle (busy_o low); the tick walks all
// nine LED entries through the state memory, one read and one write-back a cycle.
// Results are shown for one cycle on done_o; the receiver cannot stall them.
// Reset (rst_ni low, asynchronous) turns every LED off except blue, which is on,
// with every blink period at 500 ms and every deadline at zero.
module led_mode_blink_controller_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  lmbc_pkg::item_t   item_i,
  output logic              busy_o,
  output logic              done_o,
  output lmbc_pkg::result_t result_o
);
  import lmbc_pkg::*;

  mem_req_t mem_req;
  entry_t   mem_rdata;

  // Sequence items and keep the lit bits
  lmbc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (item_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .result_o    (result_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // Hold per-LED mode, period and deadline
  lmbc_entry_mem u_entry_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lmbc_pkg::*;

  localparam int unsigned RANDOM_CMDS = 1000;
  localparam int unsigned SETTLE_CYCLES = 24;

  logic    clk_i;
  logic    rst_ni = 1'b0;
  logic    start_i = 1'b0;
  item_t   item_i = '0;
  logic    busy_o;
  logic    done_o;
  result_t result_o;

  led_mode_blink_controller_core u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .item_i   (item_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // Free-running 50 MHz clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  item_t       led_cmds[$];
  result_t     predicted_results[$];
  logic        took_item = 1'b0;
  int unsigned gap_left = 0;
  int unsigned quiet_left = 0;
  int unsigned mismatches = 0;

  // Shadow copy of the LED controller state
  mode_e                led_state   [LED_TOTAL];
  logic [31:0]          half_period [LED_TOTAL];
  logic [31:0]          due_ms      [LED_TOTAL];
  logic [LED_TOTAL-1:0] lit_now;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
  endtask

  task automatic reset_led_shadow();
    for (int i = 0; i < LED_TOTAL; i++) begin
      led_state[i]   = (i == BLUE_LED) ? MODE_ON : MODE_OFF;
      half_period[i] = DEFAULT_PERIOD;
      due_ms[i]      = 32'd0;
    end
    lit_now = '0;
    lit_now[BLUE_LED] = 1'b1;
  endtask

  // Light or darken one LED; any color LED write darkens the whole color group first
  task automatic set_lit(input int idx, input logic on);
    if (idx < NUM_MONO_LEDS) begin
      lit_now[idx] = on;
    end else if (idx < LED_TOTAL) begin
      for (int k = NUM_MONO_LEDS; k < LED_TOTAL; k++) begin
        lit_now[k] = 1'b0;
      end
      lit_now[idx] = on;
    end
  endtask

  task automatic show_indicator(input int idx, input logic on);
    if (idx < NUM_MONO_LEDS) begin
      set_lit(idx, on);
      led_state[idx] = on ? MODE_ON : MODE_OFF;
    end
  endtask

  // Advance the shadow state by one item and work out its result
  task automatic apply_led_cmd(input item_t cmd, output result_t res);
    int          idx;
    logic [31:0] lag;
    logic        ten, thirty, sixty;
    idx = int'(cmd.led_sel);
    res = '0;
    case (cmd.operation)
      OP_SET_MODE: begin
        if (idx < LED_TOTAL) begin
          if (cmd.mode_code == MODE_BLINK) begin
            led_state[idx]   = MODE_BLINK;
            half_period[idx] = (cmd.blink_interval == 32'd0) ? DEFAULT_PERIOD
                                                              : cmd.blink_interval;
            due_ms[idx]      = cmd.now_ms + half_period[idx];
            set_lit(idx, 1'b1);
          end else if (cmd.mode_code == MODE_ON) begin
            led_state[idx] = MODE_ON;
            set_lit(idx, 1'b1);
          end else begin
            // unknown mode code acts as off
            led_state[idx] = MODE_OFF;
            set_lit(idx, 1'b0);
          end
        end
      end
      OP_TICK: begin
        for (int i = 0; i < LED_TOTAL; i++) begin
          lag = cmd.now_ms - due_ms[i];
          if (led_state[i] == MODE_BLINK && !lag[31]) begin
            set_lit(i, !lit_now[i]);
            due_ms[i] = cmd.now_ms + half_period[i];
          end
        end
      end
      OP_TIME_SEL: begin
        ten = 1'b0;
        thirty = 1'b0;
        sixty = 1'b0;
        if (cmd.minutes == ALL_INDICATORS) begin
          ten = 1'b1;
          thirty = 1'b1;
          sixty = 1'b1;
        end else if (cmd.minutes >= MINUTES_60) begin
          sixty = 1'b1;
        end else if (cmd.minutes >= MINUTES_30) begin
          thirty = 1'b1;
        end else if (cmd.minutes >= MINUTES_10) begin
          ten = 1'b1;
        end
        show_indicator(IND_10, ten);
        show_indicator(IND_30, thirty);
        show_indicator(IND_60, sixty);
      end
      default: begin
        if (idx < LED_TOTAL) begin
          res.read_value = lit_now[idx];
        end
      end
    endcase
    res.lit_mask = MASK_W'(lit_now);
  endtask

  function automatic item_t make_cmd(input op_e op, input int unsigned idx,
                                     input int unsigned mode, input logic [31:0] interval,
                                     input int unsigned mins, input logic [31:0] now);
    item_t c;
    c.operation      = op;
    c.led_sel        = idx[3:0];
    c.mode_code      = mode[1:0];
    c.blink_interval = interval;
    c.minutes        = mins[15:0];
    c.now_ms         = now;
    return c;
  endfunction

  // Idle cycles before the next item; runs of back-to-back items come and go
  function automatic int unsigned draw_gap();
    if (quiet_left != 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      quiet_left = $urandom_range(20, 60);
    end
    return $urandom_range(0, 13);
  endfunction

  // Present items at the falling edge, hold start until the block takes the item
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && !took_item) begin
      start_i <= 1'b1;
    end else if (gap_left != 0) begin
      start_i  <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (led_cmds.size() != 0) begin
      item_i   <= led_cmds.pop_front();
      start_i  <= 1'b1;
      gap_left <= draw_gap();
    end else begin
      start_i <= 1'b0;
    end
  end

  // Check results and predict accepted items at the rising edge
  always @(posedge clk_i) begin : watch_results
    result_t want;
    result_t fresh;
    if (!rst_ni) begin
      took_item <= 1'b0;
      reset_led_shadow();
    end else begin
      if (done_o) begin
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding, lit_mask %h",
                                    result_o.lit_mask));
        end else begin
          want = predicted_results.pop_front();
          if (result_o.lit_mask !== want.lit_mask) begin
            report_mismatch($sformatf("lit_mask %h, expected %h",
                                      result_o.lit_mask, want.lit_mask));
          end
          if (result_o.read_value !== want.read_value) begin
            report_mismatch($sformatf("read_value %b, expected %b",
                                      result_o.read_value, want.read_value));
          end
        end
      end
      took_item <= start_i && !busy_o;
      if (start_i && !busy_o) begin
        apply_led_cmd(item_i, fresh);
        predicted_results.push_back(fresh);
      end
    end
  end

  // Hold reset at start, release it at a falling edge
  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Build the item list, then wait for the block to drain
  initial begin : stimulus
    logic [31:0] clock_ms;
    item_t       c;
    int unsigned roll;
    int unsigned pick;
    logic [15:0] minute_marks [10];
    minute_marks = '{16'd0, 16'd9, 16'd10, 16'd29, 16'd30, 16'd59, 16'd60,
                     16'd254, 16'd255, 16'd256};

    // Directed: reset state, color group, blink timing and wrap, time select
    led_cmds.push_back(make_cmd(OP_READ, BLUE_LED, 0, 0, 0, 0));
    led_cmds.push_back(make_cmd(OP_READ, 15, 0, 0, 0, 0));
    led_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0));
    led_cmds.push_back(make_cmd(OP_SET_MODE, 0, MODE_ON, 32'hFFFF_FFFF, 16'hFFFF, 0));
    led_cmds.push_back(make_cmd(OP_SET_MODE, 5, MODE_ON, 0, 0, 0));
    led_cmds.push_back(make_cmd(OP_SET_MODE, 5, 3, 0, 0, 0));
    led_cmds.push_back(make_cmd(OP_SET_MODE, 6, MODE_ON, 0, 0, 0));
    led_cmds.push_back(make_cmd(OP_SET_MODE, 7, MODE_BLINK, 0, 0, 100));
    led_cmds.push_back(make_cmd(OP_READ, 6, 0, 0, 0, 0));
    led_cmds.push_back(make_cmd(OP_SET_MODE, 6, MODE_OFF, 0, 0, 0));
    led_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 599));
    led_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 600));
    led_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 1100));
    led_cmds.push_back(make_cmd(OP_SET_MODE, 1, MODE_BLINK, 32'hFFFF_FFFF, 0,
                                32'hFFFF_FFFF));
    led_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF));
    led_cmds.push_back(make_cmd(OP_SET_MODE, 9, MODE_ON, 0, 0, 0));
    led_cmds.push_back(make_cmd(OP_SET_MODE, 15, MODE_BLINK, 7, 0, 0));
    led_cmds.push_back(make_cmd(OP_TIME_SEL, 0, 0, 0, 9, 0));
    led_cmds.push_back(make_cmd(OP_TIME_SEL, 0, 0, 0, 10, 0));
    led_cmds.push_back(make_cmd(OP_TIME_SEL, 0, 0, 0, 30, 0));
    led_cmds.push_back(make_cmd(OP_TIME_SEL, 0, 0, 0, 60, 0));
    led_cmds.push_back(make_cmd(OP_TIME_SEL, 0, 0, 0, 255, 0));
    led_cmds.push_back(make_cmd(OP_READ, IND_60, 0, 0, 0, 0));
    led_cmds.push_back(make_cmd(OP_TIME_SEL, 0, 0, 0, 16'hFFFF, 0));

    // Random: a running millisecond clock so blinks actually come due
    clock_ms = $urandom;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      c.led_sel        = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(0, LED_TOTAL - 1))
                                                      : 4'($urandom_range(LED_TOTAL, 15));
      c.mode_code      = 2'($urandom_range(0, 3));
      c.blink_interval = $urandom;
      c.minutes        = 16'($urandom_range(0, 16'hFFFF));
      c.now_ms         = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        c.operation = OP_SET_MODE;
        if ($urandom_range(0, 2) == 0) begin
          c.mode_code = MODE_BLINK;
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          c.blink_interval = 32'd0;
        end else if (pick < 8) begin
          c.blink_interval = $urandom_range(1, 1500);
        end
        c.now_ms = clock_ms;
      end else if (roll < 65) begin
        c.operation = OP_TICK;
        if ($urandom_range(0, 19) == 0) begin
          clock_ms = clock_ms + $urandom;
        end else begin
          clock_ms = clock_ms + $urandom_range(0, 800);
        end
        c.now_ms = clock_ms;
      end else if (roll < 78) begin
        c.operation = OP_TIME_SEL;
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          c.minutes = minute_marks[$urandom_range(0, 9)];
        end else if (pick < 8) begin
          c.minutes = 16'($urandom_range(0, 300));
        end
      end else begin
        c.operation = OP_READ;
      end
      led_cmds.push_back(c);
    end

    // Drain: everything sent, everything answered, then a quiet stretch
    wait (rst_ni);
    while (led_cmds.size() != 0 || start_i || predicted_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (predicted_results.size() != 0) begin
      c = '0;
      void'(predicted_results.pop_front());
      report_mismatch("expected result never arrived");
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
